>>> rtl/core/metropolis_orbital_sampler_defines.svh
// Assertion macros for the sampler's top-level RTL file.
`ifndef METROPOLIS_ORBITAL_SAMPLER_DEFINES_SVH
`define METROPOLIS_ORBITAL_SAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MOS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MOS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mos_pkg.sv
// Types, constants and tables shared by the Metropolis sampler modules.
package mos_pkg;

  localparam int COORD_W = 24;
  localparam int CFG_W   = 20;
  localparam int RAND_W  = 16;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 48;

  localparam logic CFG_STEP_SIZE = 1'b0;
  localparam logic CFG_INV_SCALE = 1'b1;

  localparam logic [CFG_W-1:0]   STEP_RESET = 20'd196608;
  localparam logic [CFG_W-1:0]   INV_RESET  = 20'd65536;
  localparam logic [COORD_W-1:0] POS_RESET  = 24'd65536;
  // floor(sqrt(3 * 2^32)), the radius of the reset position.
  localparam logic [COORD_W-1:0] RAD_RESET  = 24'd113511;
  localparam logic [SQ_W-1:0]    ZSQ_RESET  = 48'h0001_0000_0000;
  localparam logic [SUM_W-1:0]   SUM_MAX    = 40'hFF_FFFF_FFFF;

  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
  // log2(e) in Q32 minus its integer part.
  localparam logic [30:0] LOG2E_FRAC = 31'd1901360723;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [3:0]  EXP_TERMS  = 4'd12;
  localparam logic [27:0] A_LIMIT    = 28'd2097152;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TRIAL_MUL, OP_TRIAL_SET, OP_SQ_MUL, OP_SQ_ADD,
    OP_SQRT_GO, OP_MAG_MUL, OP_EXP_A, OP_EXP_B_MUL, OP_EXP_B, OP_EXP_G_MUL,
    OP_EXP_G, OP_H_MUL, OP_H_REC, OP_H_QN, OP_H_FIX, OP_E_SET, OP_W_LOAD,
    OP_W_MUL, OP_W_ACC, OP_W_SAVE, OP_DECIDE, OP_COMMIT
  } op_t;

  typedef enum logic [1:0] {W_UQ_ZC, W_ZN_E, W_UQ_E, W_ACC_ZC} wsel_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  axis;
    logic [3:0]  n;
    logic [1:0]  limb;
    wsel_t       wsel;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic e_zero;
    logic rad_ge;
    logic out_free;
  } sts_t;

  // floor(2^32 / n) for the series divisors.
  function automatic logic [32:0] recip(input logic [3:0] n);
    logic [32:0] r;
    case (n)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/mos_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module mos_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mos_pkg::SQ_W-1:0]  radicand,
  output logic                      done,
  output logic [mos_pkg::COORD_W-1:0] root
);
  import mos_pkg::*;

  logic [SQ_W-1:0] sh;
  logic [25:0]     rem;
  logic [4:0]      cnt;
  logic            run;
  logic [27:0]     rem_s;
  logic [27:0]     trial;

  assign rem_s = {rem, sh[SQ_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        sh  <= radicand;
        rem <= '0;
        root <= '0;
      end else if (run) begin
        sh  <= {sh[SQ_W-3:0], 2'b00};
        cnt <= cnt + 5'd1;
        if (rem_s >= trial) begin
          rem  <= 26'(rem_s - trial);
          root <= {root[COORD_W-2:0], 1'b1};
        end else begin
          rem  <= rem_s[25:0];
          root <= {root[COORD_W-2:0], 1'b0};
        end
        if (cnt == 5'd23) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/mos_dp.sv
// Datapath: state, shared multiplier, exponential series and wide compare.
module mos_dp (
  input  logic             clk,
  input  logic             rst,
  input  mos_pkg::cmd_t    cmd,
  output mos_pkg::sts_t    sts,
  input  logic [63:0]      s_tdata,   // rand_x, rand_y, rand_z, rand_accept
  input  logic             s_tuser,   // block_start
  output logic [135:0]     m_tdata,   // pos_x, pos_y, pos_z, radius, block_radius_sum
  output logic             m_tuser,   // accepted
  output logic             m_tvalid,
  input  logic             m_tready,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [mos_pkg::CFG_W-1:0] cfg_wdata
);
  import mos_pkg::*;

  logic [CFG_W-1:0] step_size, inv_scale;
  logic [RAND_W-1:0] rx, ry, rz, ra;
  logic bstart;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, tx, ty, tz;
  logic signed [COORD_W-1:0] o_x, o_y, o_z;
  logic [COORD_W-1:0] rad_cur, rad_new, o_rad;
  logic [SUM_W-1:0] radius_sum, o_sum;
  logic o_acc;
  logic [SQ_W-1:0] ssq, zn2, zc2;
  logic [28:0] a24;
  logic ezero;
  logic [4:0] kx;
  logic [23:0] fx;
  logic [31:0] g, hx, hq;
  logic [32:0] hacc, e;
  logic [63:0] wa, wb;
  logic [127:0] wacc, lhs;
  logic take;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;

  logic [RAND_W-1:0] u_sel;
  logic signed [17:0] t_sel;
  logic signed [COORD_W-1:0] pos_sel, trial_sel, trial_sat;
  logic [COORD_W-1:0] abs_t, mag, radius;
  logic signed [39:0] tsum;
  logic [27:0] a_val;
  logic [29:0] b_val;
  logic [31:0] hr, hquo;
  logic [127:0] pp;
  logic [40:0] nsum;
  logic rad_ge, sq_done;
  logic [COORD_W-1:0] sq_root;

  mos_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQRT_GO),
    .radicand (ssq),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    case (cmd.axis)
      2'd0:    begin u_sel = rx; pos_sel = pos_x; trial_sel = tx; end
      2'd1:    begin u_sel = ry; pos_sel = pos_y; trial_sel = ty; end
      default: begin u_sel = rz; pos_sel = pos_z; trial_sel = tz; end
    endcase
  end

  assign t_sel = $signed({1'b0, u_sel, 1'b0}) - 18'sd65536;
  assign abs_t = trial_sel[COORD_W-1] ? COORD_W'(-trial_sel) : trial_sel;
  assign rad_ge = rad_new >= rad_cur;
  assign mag = rad_ge ? rad_new - rad_cur : rad_cur - rad_new;
  // The step offset is floor(prod / 2^16), an arithmetic shift.
  assign tsum = {{16{pos_sel[COORD_W-1]}}, pos_sel} + $signed(prod[55:16]);

  always_comb begin
    if (tsum > 40'sd8388607) begin
      trial_sat = 24'sh7FFFFF;
    end else if (tsum < -40'sd8388608) begin
      trial_sat = 24'sh800000;
    end else begin
      trial_sat = tsum[COORD_W-1:0];
    end
  end

  assign a_val = prod[43:16];
  assign b_val = {1'b0, a24} + {2'b00, prod[59:32]};
  assign hr    = hx - prod[31:0];
  assign hquo  = hq + {31'b0, (hr >= {28'b0, cmd.n})};
  assign radius = take ? rad_new : rad_cur;
  assign nsum  = {1'b0, bstart ? {SUM_W{1'b0}} : radius_sum} + {17'b0, radius};

  always_comb begin
    case (cmd.limb)
      2'd0:    pp = {64'b0, prod[63:0]};
      2'd3:    pp = {prod[63:0], 64'b0};
      default: pp = {32'b0, prod[63:0], 32'b0};
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_TRIAL_MUL: begin
        ma = {14'b0, step_size};
        mb = {{16{t_sel[17]}}, t_sel};
      end
      OP_SQ_MUL: begin
        ma = {10'b0, abs_t};
        mb = {10'b0, abs_t};
      end
      OP_MAG_MUL: begin
        ma = {10'b0, mag};
        mb = {14'b0, inv_scale};
      end
      OP_EXP_B_MUL: begin
        ma = {5'b0, a24};
        mb = {3'b0, LOG2E_FRAC};
      end
      OP_EXP_G_MUL: begin
        ma = {10'b0, fx};
        mb = {2'b0, LN2_Q32};
      end
      OP_H_MUL: begin
        ma = {2'b0, g};
        mb = {1'b0, hacc};
      end
      OP_H_REC: begin
        ma = {2'b0, prod[63:32]};
        mb = {1'b0, recip(cmd.n)};
      end
      OP_H_QN: begin
        ma = {2'b0, prod[63:32]};
        mb = {30'b0, cmd.n};
      end
      OP_W_MUL: begin
        ma = {2'b0, cmd.limb[1] ? wa[63:32] : wa[31:0]};
        mb = {2'b0, cmd.limb[0] ? wb[63:32] : wb[31:0]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Working registers of one move attempt.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (sq_done) begin
      rad_new <= sq_root;
    end
    case (cmd.op)
      OP_LOAD: begin
        rx <= s_tdata[15:0];
        ry <= s_tdata[31:16];
        rz <= s_tdata[47:32];
        ra <= s_tdata[63:48];
        bstart <= s_tuser;
      end
      OP_TRIAL_SET: begin
        case (cmd.axis)
          2'd0:    tx <= trial_sat;
          2'd1:    ty <= trial_sat;
          default: tz <= trial_sat;
        endcase
      end
      OP_SQ_ADD: begin
        ssq <= ((cmd.axis == 2'd0) ? {SQ_W{1'b0}} : ssq) + prod[SQ_W-1:0];
        if (cmd.axis == 2'd2) begin
          zn2 <= prod[SQ_W-1:0];
        end
      end
      OP_EXP_A: begin
        ezero <= a_val >= A_LIMIT;
        a24   <= {a_val[20:0], 8'b0};
      end
      OP_EXP_B: begin
        kx    <= b_val[28:24];
        fx    <= b_val[23:0];
        ezero <= ezero | b_val[29];
      end
      OP_EXP_G: begin
        g    <= prod[55:24];
        hacc <= ONE_Q32;
      end
      OP_H_REC: hx <= prod[63:32];
      OP_H_QN:  hq <= prod[63:32];
      OP_H_FIX: hacc <= ONE_Q32 - {1'b0, hquo};
      OP_E_SET: e <= ezero ? '0 : (hacc >> kx);
      OP_W_LOAD: begin
        wacc <= '0;
        case (cmd.wsel)
          W_UQ_ZC: begin wa <= {32'b0, ra, 16'b0}; wb <= {16'b0, zc2}; end
          W_ZN_E:  begin wa <= {16'b0, zn2};       wb <= {31'b0, e};   end
          W_UQ_E:  begin wa <= {32'b0, ra, 16'b0}; wb <= {31'b0, e};   end
          default: begin wa <= wacc[63:0];         wb <= {16'b0, zc2}; end
        endcase
      end
      OP_W_ACC:  wacc <= wacc + pp;
      OP_W_SAVE: lhs <= wacc;
      OP_DECIDE: take <= rad_ge ? (lhs <= wacc) : (wacc <= {16'b0, zn2, 64'b0});
      OP_COMMIT: begin
        o_x   <= take ? tx : pos_x;
        o_y   <= take ? ty : pos_y;
        o_z   <= take ? tz : pos_z;
        o_acc <= take;
        o_rad <= radius;
        o_sum <= nsum[SUM_W] ? SUM_MAX : nsum[SUM_W-1:0];
      end
      default: ;
    endcase
  end

  // Persistent sampler state, configuration and the output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= STEP_RESET;
      inv_scale  <= INV_RESET;
      pos_x      <= POS_RESET;
      pos_y      <= POS_RESET;
      pos_z      <= POS_RESET;
      rad_cur    <= RAD_RESET;
      zc2        <= ZSQ_RESET;
      radius_sum <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_STEP_SIZE: step_size <= cfg_wdata;
          CFG_INV_SCALE: inv_scale <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == OP_COMMIT) begin
        m_tvalid   <= 1'b1;
        radius_sum <= nsum[SUM_W] ? SUM_MAX : nsum[SUM_W-1:0];
        if (take) begin
          pos_x   <= tx;
          pos_y   <= ty;
          pos_z   <= tz;
          rad_cur <= rad_new;
          zc2     <= zn2;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {o_sum, o_rad, o_z, o_y, o_x};
  assign m_tuser = o_acc;

  assign sts = '{sqrt_done: sq_done, e_zero: ezero, rad_ge: rad_ge,
                 out_free: (!m_tvalid || m_tready)};

endmodule

>>> rtl/core/mos_ctrl.sv
// Controller: sequences one move attempt through the datapath.
module mos_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output mos_pkg::cmd_t  cmd,
  input  mos_pkg::sts_t  sts
);
  import mos_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TR_MUL, S_TR_SET, S_SQ_MUL, S_SQ_ADD, S_SQRT_GO, S_SQRT_WAIT,
    S_MAG_MUL, S_EXP_A, S_EXP_B_MUL, S_EXP_B, S_EXP_G_MUL, S_EXP_G,
    S_H_MUL, S_H_REC, S_H_QN, S_H_FIX, S_E_SET, S_W_LOAD, S_W_MUL, S_W_ACC,
    S_W_SAVE, S_DECIDE, S_COMMIT
  } state_t;

  state_t     state;
  logic [1:0] axis;
  logic [3:0] n;
  logic [1:0] limb;
  logic       wp;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.axis = axis;
    cmd.n    = n;
    cmd.limb = limb;
    if (sts.rad_ge) begin
      cmd.wsel = wp ? W_ZN_E : W_UQ_ZC;
    end else begin
      cmd.wsel = wp ? W_ACC_ZC : W_UQ_E;
    end
    case (state)
      S_IDLE:      cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
      S_TR_MUL:    cmd.op = OP_TRIAL_MUL;
      S_TR_SET:    cmd.op = OP_TRIAL_SET;
      S_SQ_MUL:    cmd.op = OP_SQ_MUL;
      S_SQ_ADD:    cmd.op = OP_SQ_ADD;
      S_SQRT_GO:   cmd.op = OP_SQRT_GO;
      S_MAG_MUL:   cmd.op = OP_MAG_MUL;
      S_EXP_A:     cmd.op = OP_EXP_A;
      S_EXP_B_MUL: cmd.op = OP_EXP_B_MUL;
      S_EXP_B:     cmd.op = OP_EXP_B;
      S_EXP_G_MUL: cmd.op = OP_EXP_G_MUL;
      S_EXP_G:     cmd.op = OP_EXP_G;
      S_H_MUL:     cmd.op = OP_H_MUL;
      S_H_REC:     cmd.op = OP_H_REC;
      S_H_QN:      cmd.op = OP_H_QN;
      S_H_FIX:     cmd.op = OP_H_FIX;
      S_E_SET:     cmd.op = OP_E_SET;
      S_W_LOAD:    cmd.op = OP_W_LOAD;
      S_W_MUL:     cmd.op = OP_W_MUL;
      S_W_ACC:     cmd.op = OP_W_ACC;
      S_W_SAVE:    cmd.op = OP_W_SAVE;
      S_DECIDE:    cmd.op = OP_DECIDE;
      S_COMMIT:    cmd.op = sts.out_free ? OP_COMMIT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      n     <= '0;
      limb  <= '0;
      wp    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_TR_MUL;
            axis  <= '0;
          end
        end
        S_TR_MUL: state <= S_TR_SET;
        S_TR_SET: begin
          if (axis == 2'd2) begin
            state <= S_SQ_MUL;
            axis  <= '0;
          end else begin
            state <= S_TR_MUL;
            axis  <= axis + 2'd1;
          end
        end
        S_SQ_MUL: state <= S_SQ_ADD;
        S_SQ_ADD: begin
          if (axis == 2'd2) begin
            state <= S_SQRT_GO;
          end else begin
            state <= S_SQ_MUL;
            axis  <= axis + 2'd1;
          end
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sts.sqrt_done) begin
            state <= S_MAG_MUL;
          end
        end
        S_MAG_MUL:   state <= S_EXP_A;
        S_EXP_A:     state <= S_EXP_B_MUL;
        S_EXP_B_MUL: state <= S_EXP_B;
        S_EXP_B:     state <= S_EXP_G_MUL;
        S_EXP_G_MUL: state <= S_EXP_G;
        S_EXP_G: begin
          // A large exponent argument gives zero without the series.
          if (sts.e_zero) begin
            state <= S_E_SET;
          end else begin
            state <= S_H_MUL;
            n     <= EXP_TERMS;
          end
        end
        S_H_MUL: state <= S_H_REC;
        S_H_REC: state <= S_H_QN;
        S_H_QN:  state <= S_H_FIX;
        S_H_FIX: begin
          if (n == 4'd1) begin
            state <= S_E_SET;
          end else begin
            state <= S_H_MUL;
            n     <= n - 4'd1;
          end
        end
        S_E_SET: begin
          state <= S_W_LOAD;
          wp    <= 1'b0;
        end
        S_W_LOAD: begin
          state <= S_W_MUL;
          limb  <= '0;
        end
        S_W_MUL: state <= S_W_ACC;
        S_W_ACC: begin
          if (limb != 2'd3) begin
            state <= S_W_MUL;
            limb  <= limb + 2'd1;
          end else if (wp) begin
            state <= S_DECIDE;
          end else if (sts.rad_ge) begin
            state <= S_W_SAVE;
          end else begin
            state <= S_W_LOAD;
            wp    <= 1'b1;
          end
        end
        S_W_SAVE: begin
          state <= S_W_LOAD;
          wp    <= 1'b1;
        end
        S_DECIDE: state <= S_COMMIT;
        S_COMMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/metropolis_orbital_sampler.sv
// A move attempt is shorter when the exponential is zero, which skips the 12-term series, and
// shorter still when the trial radius is below the current one.
// One item is in flight; the next input is taken only after the result is registered, so the
// sampler does not take a new input while a move attempt is in progress.
// The result register lets a finished result wait while the next input is taken.
// Synchronous reset sets position to (1,1,1), clears the radius sum and restores both registers.
module metropolis_orbital_sampler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // rand_x, rand_y, rand_z, rand_accept
  input  logic         s_tuser,   // block_start
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // pos_x, pos_y, pos_z, radius, block_radius_sum
  output logic         m_tuser,   // accepted
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [19:0]  cfg_wdata
);
  import mos_pkg::*;

  `include "metropolis_orbital_sampler_defines.svh"

  cmd_t cmd;
  sts_t sts;

  mos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mos_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  `MOS_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second input taken while busy")
  `MOS_ASSERT_NOW(a_result_ends_work, clk, rst, $rose(m_tvalid), s_tready, "result without return to idle")
  `MOS_ASSERT_NOW(a_sum_covers_radius, clk, rst, m_tvalid, m_tdata[135:96] >= {16'b0, m_tdata[95:72]}, "radius sum below radius")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the Metropolis orbital sampler: stream driver, monitor, predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mos_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rz;
    logic [15:0] ru;
    logic        blk;
  } move_t;

  typedef struct packed {
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
    logic        acc;
    logic [23:0] rad;
    logic [39:0] sum;
  } sample_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = CFG_STEP_SIZE;
  logic [19:0]  cfg_wdata = '0;

  metropolis_orbital_sampler DUT (.*);

  always #4 clk = ~clk;

  // Predictor copy of the sampler state and registers.
  logic signed [23:0] cur_x, cur_y, cur_z;
  logic [39:0]        sum_q;
  logic [31:0]        moves_taken;
  logic [19:0]        step_q, inv_q;

  move_t   moves_pending[$];
  sample_t samples_due[$];
  move_t   drv_move;
  bit      hold_moves = 1'b1;
  bit      failed = 1'b0;
  int      burst_left = 0, gap_left = 0, stall_left = 0, run_left = 0;
  int      quiet_cycles = 0;

  function automatic logic signed [23:0] sat24(input longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] trial(input logic signed [23:0] p,
                                               input logic [15:0] u);
    longint t, d;
    t = longint'({u, 1'b0}) - 65536;
    d = (longint'(step_q) * t) >>> 16;
    return sat24(longint'(p) + d);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // exp(-a) as Q1.32 from a Q.16 argument, via 2^-k and a truncated series.
  function automatic logic [63:0] exp_q32(input logic [63:0] a);
    logic [63:0] b, k, f, g, acc;
    if (a >= (64'd32 << 16)) return 0;
    b = ((a << 8) * 64'd6196328019) >> 32;
    k = b >> 24;
    if (k >= 32) return 0;
    f = b & 64'hFF_FFFF;
    g = (f * 64'd2977044472) >> 24;
    acc = 64'h1_0000_0000;
    for (int n = 12; n >= 1; n--)
      acc = 64'h1_0000_0000 - ((g * acc) >> 32) / n;
    return acc >> k;
  endfunction

  function automatic sample_t take_step(input move_t m);
    sample_t s;
    logic signed [23:0] tx, ty, tz;
    logic [63:0] zc2, zn2, r_cur, r_new, mag, e, uq, ue, rad;
    logic [127:0] lhs, rhs;
    logic ok;
    tx = trial(cur_x, m.rx);
    ty = trial(cur_y, m.ry);
    tz = trial(cur_z, m.rz);
    zc2 = longint'(cur_z) * longint'(cur_z);
    zn2 = longint'(tz) * longint'(tz);
    r_cur = isqrt(longint'(cur_x) * longint'(cur_x) + longint'(cur_y) * longint'(cur_y) + zc2);
    r_new = isqrt(longint'(tx) * longint'(tx) + longint'(ty) * longint'(ty) + zn2);
    mag = (r_new >= r_cur) ? r_new - r_cur : r_cur - r_new;
    e = exp_q32((mag * inv_q) >> 16);
    uq = 64'(m.ru) << 16;
    if (r_new >= r_cur) begin
      lhs = {64'd0, uq} * {64'd0, zc2};
      rhs = {64'd0, zn2} * {64'd0, e};
    end else begin
      ue = uq * e;
      lhs = {64'd0, ue} * {64'd0, zc2};
      rhs = {zn2, 64'd0};
    end
    ok = (lhs <= rhs);
    if (ok) begin
      cur_x = tx;
      cur_y = ty;
      cur_z = tz;
      moves_taken++;
      rad = r_new;
    end else begin
      rad = r_cur;
    end
    if (m.blk) sum_q = 0;
    if ({24'd0, sum_q} + rad > 64'hFF_FFFF_FFFF) sum_q = SUM_MAX;
    else sum_q = sum_q + rad[39:0];
    s.px = cur_x;
    s.py = cur_y;
    s.pz = cur_z;
    s.acc = ok;
    s.rad = rad[23:0];
    s.sum = sum_q;
    return s;
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    logic nv;
    if (!rst) begin
      if (s_tvalid && s_tready) samples_due.push_back(take_step(drv_move));
      nv = 1'b0;
      if (s_tvalid && !s_tready) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (moves_pending.size() > 0 && !hold_moves) begin
        drv_move = moves_pending.pop_front();
        nv = 1'b1;
        s_tdata <= {drv_move.ru, drv_move.rz, drv_move.ry, drv_move.rx};
        s_tuser <= drv_move.blk;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      s_tvalid <= nv;
    end
  end

  // Monitor and result-side stall pattern.
  always @(posedge clk) begin
    sample_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tuser,
               m_tdata[95:72], m_tdata[135:96]};
        if (samples_due.size() == 0) begin
          $error("result transfer with no prediction waiting");
          failed = 1'b1;
        end else begin
          want = samples_due.pop_front();
          if (got.px !== want.px) begin
            $error("pos_x expected %h got %h", want.px, got.px); failed = 1'b1;
          end
          if (got.py !== want.py) begin
            $error("pos_y expected %h got %h", want.py, got.py); failed = 1'b1;
          end
          if (got.pz !== want.pz) begin
            $error("pos_z expected %h got %h", want.pz, got.pz); failed = 1'b1;
          end
          if (got.acc !== want.acc) begin
            $error("accepted expected %b got %b", want.acc, got.acc); failed = 1'b1;
          end
          if (got.rad !== want.rad) begin
            $error("radius expected %h got %h", want.rad, got.rad); failed = 1'b1;
          end
          if (got.sum !== want.sum) begin
            $error("block_radius_sum expected %h got %h", want.sum, got.sum);
            failed = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        m_tready <= 1'b1;
      end else begin
        run_left = $urandom_range(1, 300);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
        m_tready <= (stall_left == 0);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_regs(input logic [19:0] step, input logic [19:0] inv);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_STEP_SIZE;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_addr <= CFG_INV_SCALE;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_q = step;
    inv_q = inv;
  endtask

  task automatic add_move(input logic [15:0] rx, ry, rz, ru, input logic blk);
    move_t m;
    m = '{rx: rx, ry: ry, rz: rz, ru: ru, blk: blk};
    moves_pending.push_back(m);
  endtask

  task automatic add_random(input int count);
    move_t m;
    repeat (count) begin
      m.rx = 16'($urandom_range(0, 65535));
      m.ry = 16'($urandom_range(0, 65535));
      m.rz = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0:       m.ru = 16'($urandom_range(0, 255));
        1:       m.ru = 16'($urandom_range(65280, 65535));
        default: m.ru = 16'($urandom_range(0, 65535));
      endcase
      m.blk = ($urandom_range(0, 15) == 0);
      moves_pending.push_back(m);
    end
  endtask

  // Releases the queued moves and waits until every result is back.
  // The check runs at the falling edge so that the driver's updates have settled.
  task automatic run_and_drain();
    hold_moves = 1'b0;
    while (moves_pending.size() > 0 || samples_due.size() > 0 || s_tvalid) @(negedge clk);
    hold_moves = 1'b1;
  endtask

  initial begin
    cur_x = 24'sd65536;
    cur_y = 24'sd65536;
    cur_z = 24'sd65536;
    sum_q = '0;
    moves_taken = '0;
    step_q = STEP_RESET;
    inv_q = INV_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: field extremes, zero step, both accept extremes, block start.
    add_move(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_move(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_move(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_move(16'h5555, 16'hAAAA, 16'h1234, 16'hFFFF, 1'b1);
    add_move(16'hAAAA, 16'h5555, 16'hEDCB, 16'h0001, 1'b0);
    add_move(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 1'b0);
    run_and_drain();

    // Unit step: walk z onto zero, then moves from z = 0 always go through.
    set_regs(20'd65536, 20'd1);
    add_move(16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
    add_move(16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
    add_move(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    add_move(16'h9000, 16'h2000, 16'hC000, 16'hFFFF, 1'b0);
    add_move(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0);
    add_random(200);
    run_and_drain();

    // Largest step and scale: drive the coordinates into saturation.
    set_regs(20'hFFFFF, 20'hFFFFF);
    repeat (10) add_move(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    repeat (10) add_move(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_random(200);
    run_and_drain();

    set_regs(20'd0, 20'd65536);
    add_random(100);
    run_and_drain();

    repeat (4) begin
      set_regs(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(1, 20'hFFFFF)));
      add_random(85);
      run_and_drain();
    end

    repeat (200) @(posedge clk);
    if (!failed && samples_due.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
